// ===== rtl/assert_macros.svh =====
// assertion macros used by the timer queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, disabled during reset
`define STQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define STQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    `STQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/stq_pkg.sv =====
// types and codes of the sorted timer queue
package stq_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;
    localparam logic [1:0] ST_NO_FIRE  = 2'd3;

    localparam int MAX_FIRES = 32;

    typedef struct packed {
        logic [63:0] deadline;
        logic [63:0] stamp;
        logic [31:0] interval;
        logic [7:0]  queue;
    } slot_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] handle_out;
        logic       fired;
        logic [7:0] fired_queue;
        logic       last;
    } result_t;

endpackage

// ===== rtl/stq_in_if.sv =====
// command channel of the timer queue
interface stq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] delay_ticks;
    logic [31:0] repeat_ticks;
    logic [7:0]  target_queue;
    logic [3:0]  slot_handle;

    modport source (output valid, operation, delay_ticks, repeat_ticks, target_queue,
                    slot_handle, input ready);
    modport sink (input valid, operation, delay_ticks, repeat_ticks, target_queue,
                  slot_handle, output ready);
endinterface

// ===== rtl/stq_out_if.sv =====
// result channel of the timer queue
interface stq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] handle_out;
    logic       fired;
    logic [7:0] fired_queue;
    logic       last;

    modport source (output valid, status, handle_out, fired, fired_queue, last,
                    input ready);
    modport sink (input valid, status, handle_out, fired, fired_queue, last,
                  output ready);
endinterface

// ===== rtl/stq_alu.sv =====
// shared saturating adder and deadline comparators
module stq_alu
    import stq_pkg::*;
(
    input  logic [63:0]  add_a,
    input  logic [31:0]  add_b,
    input  logic [127:0] key_a,
    input  logic [127:0] key_b,
    input  logic [63:0]  le_a,
    input  logic [63:0]  le_b,
    output logic [63:0]  sum_sat,
    output logic         key_lt,
    output logic         le
);
    logic [64:0] sum;

    assign sum     = {1'b0, add_a} + {33'b0, add_b};
    assign sum_sat = sum[64] ? {64{1'b1}} : sum[63:0];
    assign key_lt  = key_a < key_b;
    assign le      = le_a <= le_b;
endmodule

// ===== rtl/stq_slot_mem.sv =====
// slot table memory, one write and one registered read port
module stq_slot_mem
    import stq_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int SW        = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  slot_t         wdata,
    input  logic [SW-1:0] raddr,
    output slot_t         rdata
);
    slot_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/sorted_timer_queue.sv =====
// sorted timer queue top level: sequencer, slot state and result register
// Commands come in one at a time and the block is not ready while one is in work.
// A delete is done in the idle state itself. A create scans the slots for the
// lowest free one. A tick scans the slots for the head timer and fires at most 32
// timers per tick; each firing but the 32nd rescans the slot memory through its
// single read port to find the next timer in deadline order, ties going to the
// earliest inserted. Results leave through a one-deep output register; a stalled
// result holds the sequencer at its next result. Slot contents need no clearing
// after reset.
`include "assert_macros.svh"

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    stq_in_if.sink    in_ch,
    stq_out_if.source out_ch
);
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FREE   = 3'd1;
    localparam logic [2:0] S_HEAD   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [31:0]          delay_reg, delay_next;
    logic [31:0]          repeat_reg, repeat_next;
    logic [7:0]           queue_reg, queue_next;
    logic [63:0]          tick_reg, tick_next;
    logic [63:0]          stamp_reg, stamp_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    slot_t                best_reg, best_next;
    logic [SW-1:0]        best_idx_reg, best_idx_next;
    logic                 found_reg, found_next;
    logic                 pend_reg, pend_next;
    logic [SW-1:0]        pend_idx_reg, pend_idx_next;
    logic [7:0]           pend_q_reg, pend_q_next;
    logic [4:0]           fire_cnt_reg, fire_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic          can_emit, emit;
    result_t       emit_data;
    logic          we;
    logic [SW-1:0] waddr;
    slot_t         wdata;
    slot_t         rdata;
    logic [63:0]   add_a, sum_sat;
    logic [31:0]   add_b;
    logic          key_lt, le;
    logic [SW-1:0] pidx, fidx, hidx;
    logic          due;

    assign can_emit = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && can_emit;

    assign pidx = SW'(cnt_reg - CW'(1));
    assign fidx = SW'(cnt_reg);
    assign hidx = SW'(in_ch.slot_handle);

    assign add_a = (state_reg == S_FREE) ? tick_reg : best_reg.deadline;
    assign add_b = (state_reg == S_FREE) ? delay_reg : best_reg.interval;
    assign due   = found_reg && le;

    stq_alu u_alu (
        .add_a   (add_a),
        .add_b   (add_b),
        .key_a   ({rdata.deadline, rdata.stamp}),
        .key_b   ({best_reg.deadline, best_reg.stamp}),
        .le_a    (best_reg.deadline),
        .le_b    (tick_reg),
        .sum_sat (sum_sat),
        .key_lt  (key_lt),
        .le      (le)
    );

    stq_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (fidx),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        delay_next    = delay_reg;
        repeat_next   = repeat_reg;
        queue_next    = queue_reg;
        tick_next     = tick_reg;
        stamp_next    = stamp_reg;
        active_next   = active_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pend_q_next   = pend_q_reg;
        fire_cnt_next = fire_cnt_reg;
        emit          = 1'b0;
        emit_data     = '0;
        we            = 1'b0;
        waddr         = best_idx_reg;
        wdata         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    case (in_ch.operation)
                        OP_TICK:
                        begin
                            tick_next     = tick_reg + 64'd1;
                            pend_next     = 1'b0;
                            fire_cnt_next = '0;
                            cnt_next      = '0;
                            found_next    = 1'b0;
                            state_next    = S_HEAD;
                        end
                        OP_CREATE:
                        begin
                            delay_next  = in_ch.delay_ticks;
                            repeat_next = in_ch.repeat_ticks;
                            queue_next  = in_ch.target_queue;
                            cnt_next    = '0;
                            state_next  = S_FREE;
                        end
                        OP_DELETE:
                        begin
                            emit                 = 1'b1;
                            emit_data.handle_out = in_ch.slot_handle;
                            emit_data.last       = 1'b1;
                            if ((32'(in_ch.slot_handle) < NUM_SLOTS) && active_reg[hidx])
                            begin
                                emit_data.status  = ST_OK;
                                active_next[hidx] = 1'b0;
                            end
                            else
                            begin
                                emit_data.status = ST_INACTIVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                if (cnt_reg == CW'(NUM_SLOTS))
                begin
                    if (can_emit)
                    begin
                        emit             = 1'b1;
                        emit_data.status = ST_FULL;
                        emit_data.last   = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else if (!active_reg[fidx])
                begin
                    if (can_emit)
                    begin
                        we                   = 1'b1;
                        waddr                = fidx;
                        wdata.deadline       = sum_sat;
                        wdata.stamp          = stamp_reg;
                        wdata.interval       = repeat_reg;
                        wdata.queue          = queue_reg;
                        stamp_next           = stamp_reg + 64'd1;
                        active_next[fidx]    = 1'b1;
                        emit                 = 1'b1;
                        emit_data.status     = ST_OK;
                        emit_data.handle_out = 4'(fidx);
                        emit_data.last       = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_HEAD:
            begin
                if (cnt_reg != '0)
                begin
                    if (active_reg[pidx] && (!found_reg || key_lt))
                    begin
                        best_next     = rdata;
                        best_idx_next = pidx;
                        found_next    = 1'b1;
                    end
                end
                if (cnt_reg == CW'(NUM_SLOTS))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_DECIDE:
            begin
                if (!due)
                begin
                    if (can_emit)
                    begin
                        emit           = 1'b1;
                        emit_data.last = 1'b1;
                        if (pend_reg)
                        begin
                            emit_data.status      = ST_OK;
                            emit_data.handle_out  = 4'(pend_idx_reg);
                            emit_data.fired       = 1'b1;
                            emit_data.fired_queue = pend_q_reg;
                        end
                        else
                        begin
                            emit_data.status = ST_NO_FIRE;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (!pend_reg || can_emit)
                begin
                    if (pend_reg)
                    begin
                        emit                  = 1'b1;
                        emit_data.status      = ST_OK;
                        emit_data.handle_out  = 4'(pend_idx_reg);
                        emit_data.fired       = 1'b1;
                        emit_data.fired_queue = pend_q_reg;
                    end
                    if (best_reg.interval != 32'd0)
                    begin
                        we             = 1'b1;
                        waddr          = best_idx_reg;
                        wdata.deadline = sum_sat;
                        wdata.stamp    = stamp_reg;
                        wdata.interval = best_reg.interval;
                        wdata.queue    = best_reg.queue;
                        stamp_next     = stamp_reg + 64'd1;
                    end
                    else
                    begin
                        active_next[best_idx_reg] = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = best_idx_reg;
                    pend_q_next   = best_reg.queue;
                    if (fire_cnt_reg == 5'(MAX_FIRES - 1))
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        fire_cnt_next = fire_cnt_reg + 5'd1;
                        cnt_next      = '0;
                        found_next    = 1'b0;
                        state_next    = S_HEAD;
                    end
                end
            end
            S_FINAL:
            begin
                if (can_emit)
                begin
                    emit                  = 1'b1;
                    emit_data.status      = ST_OK;
                    emit_data.handle_out  = 4'(pend_idx_reg);
                    emit_data.fired       = 1'b1;
                    emit_data.fired_queue = pend_q_reg;
                    emit_data.last        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !out_ch.ready);
        out_next       = emit ? emit_data : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            stamp_reg     <= '0;
            active_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            fire_cnt_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            stamp_reg     <= stamp_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            fire_cnt_reg  <= fire_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg    <= delay_next;
        repeat_reg   <= repeat_next;
        queue_reg    <= queue_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_q_reg   <= pend_q_next;
        out_reg      <= out_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_reg.status;
    assign out_ch.handle_out  = out_reg.handle_out;
    assign out_ch.fired       = out_reg.fired;
    assign out_ch.fired_queue = out_reg.fired_queue;
    assign out_ch.last        = out_reg.last;

    `STQ_ASSERT_IMPL(a_ready_idle, in_ch.ready, state_reg == S_IDLE, "ready outside idle")
    `STQ_ASSERT_IMPL(a_final_pend, state_reg == S_FINAL, pend_reg, "final without pending item")
    `STQ_ASSERT_IMPL(a_fired_ok, out_valid_reg && out_reg.fired, out_reg.status == ST_OK,
                     "fired item with bad status")
    `STQ_ASSERT_IMPL(a_decide_scan, state_reg == S_DECIDE,
                     ($past(state_reg) == S_HEAD) || ($past(state_reg) == S_DECIDE),
                     "decide without full scan")
endmodule

// ===== sim/sorted_timer_queue_tb.sv =====
// self-checking testbench of the sorted timer queue: directed table, then random commands
module sorted_timer_queue_tb;
    import stq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 16;
    localparam int WATCH_MAX = 20000;
    localparam int N_RANDOM  = 60;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] dly;
        logic [31:0] rpt;
        logic [7:0]  q;
        logic [3:0]  h;
        int          cnt;
        bit          typed;
        logic [1:0]  st;
        logic [3:0]  ho;
    } row_t;

    logic clk;
    logic rst_n;
    stq_in_if  in_ch ();
    stq_out_if out_ch ();

    sorted_timer_queue #(.NUM_SLOTS(SLOTS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [63:0] now_tick;
    logic [63:0] due [SLOTS];
    logic [31:0] reload [SLOTS];
    logic [7:0]  dest [SLOTS];
    bit          busy [SLOTS];
    int          order [SLOTS];
    int          order_len;

    result_t pending_results [$];
    int      errors;
    int      idle_cycles;
    bit      calm;
    row_t    dir_tbl [14];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic void order_drop(int pos);
        for (int i = pos; i + 1 < order_len; i++)
            order[i] = order[i + 1];
        order_len--;
    endfunction

    function automatic void order_link(int s);
        int pos;
        pos = 0;
        if (order_len >= SLOTS)
            return;
        while (pos < order_len && due[order[pos]] <= due[s])
            pos++;
        for (int i = order_len; i > pos; i--)
            order[i] = order[i - 1];
        order[pos] = s;
        order_len++;
    endfunction

    function automatic result_t mk(logic [1:0] st, logic [3:0] ho, logic f,
                                   logic [7:0] fq, logic l);
        result_t r;
        r.status = st; r.handle_out = ho; r.fired = f; r.fired_queue = fq; r.last = l;
        return r;
    endfunction

    function automatic void predict_timers(logic [1:0] op, logic [31:0] dly,
                                           logic [31:0] rpt, logic [7:0] q, logic [3:0] h);
        int s;
        int n;
        if (op == OP_CREATE) begin
            s = 0;
            while (s < SLOTS && busy[s])
                s++;
            if (s >= SLOTS || order_len >= SLOTS) begin
                pending_results.push_back(mk(ST_FULL, 4'd0, 1'b0, 8'd0, 1'b1));
            end
            else begin
                due[s] = sat_sum(now_tick, {32'd0, dly});
                reload[s] = rpt;
                dest[s] = q;
                busy[s] = 1'b1;
                order_link(s);
                pending_results.push_back(mk(ST_OK, s[3:0], 1'b0, 8'd0, 1'b1));
            end
        end
        else if (op == OP_DELETE) begin
            if (!busy[h]) begin
                pending_results.push_back(mk(ST_INACTIVE, h, 1'b0, 8'd0, 1'b1));
            end
            else begin
                for (int i = 0; i < order_len; i++)
                    if (order[i] == h) begin
                        order_drop(i);
                        break;
                    end
                busy[h] = 1'b0;
                pending_results.push_back(mk(ST_OK, h, 1'b0, 8'd0, 1'b1));
            end
        end
        else if (op == OP_TICK) begin
            n = 0;
            now_tick = now_tick + 64'd1;
            while (n < MAX_FIRES && order_len > 0) begin
                s = order[0];
                if (due[s] > now_tick)
                    break;
                order_drop(0);
                pending_results.push_back(mk(ST_OK, s[3:0], 1'b1, dest[s], 1'b0));
                if (reload[s] != 0) begin
                    due[s] = sat_sum(due[s], {32'd0, reload[s]});
                    order_link(s);
                end
                else begin
                    busy[s] = 1'b0;
                end
                n++;
            end
            if (n == 0)
                pending_results.push_back(mk(ST_NO_FIRE, 4'd0, 1'b0, 8'd0, 1'b1));
            else
                pending_results[$].last = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // drives one item and waits for it to be taken; valid stays high when no gap follows
    task automatic send_command(logic [1:0] op, logic [31:0] dly, logic [31:0] rpt,
                                logic [7:0] q, logic [3:0] h, bit typed,
                                logic [1:0] st, logic [3:0] ho);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.delay_ticks <= dly;
        in_ch.repeat_ticks <= rpt;
        in_ch.target_queue <= q;
        in_ch.slot_handle <= h;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_timers(op, dly, rpt, q, h);
        if (typed)
            pending_results[$] = mk(st, ho, 1'b0, 8'd0, 1'b1);
        @(negedge clk);
    endtask

    // result side
    always @(negedge clk) begin
        if (calm)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result count", 1, 0);
            end
            else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.handle_out !== want.handle_out)
                    report_mismatch("handle_out", out_ch.handle_out, want.handle_out);
                if (out_ch.fired !== want.fired)
                    report_mismatch("fired", out_ch.fired, want.fired);
                if (out_ch.fired_queue !== want.fired_queue)
                    report_mismatch("fired_queue", out_ch.fired_queue, want.fired_queue);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX) begin
            $display("timeout at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int sent;
        int r;
        logic [1:0]  op;
        logic [31:0] dly;
        logic [31:0] rpt;
        int          waited;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.delay_ticks = '0;
        in_ch.repeat_ticks = '0;
        in_ch.target_queue = '0;
        in_ch.slot_handle = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        now_tick = '0;
        order_len = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            busy[i] = 1'b0; due[i] = '0; reload[i] = '0; dest[i] = '0; order[i] = 0;
        end

        dir_tbl = '{
            '{OP_TICK,   32'd0, 32'd0, 8'h00, 4'd0,  1, 1'b1, ST_NO_FIRE,  4'd0},
            '{OP_DELETE, 32'd0, 32'd0, 8'h00, 4'd5,  1, 1'b1, ST_INACTIVE, 4'd5},
            '{OP_DELETE, 32'd0, 32'd0, 8'h00, 4'd15, 1, 1'b1, ST_INACTIVE, 4'd15},
            '{OP_UNUSED, 32'd7, 32'd7, 8'h11, 4'd3,  1, 1'b0, ST_OK,       4'd0},
            '{OP_CREATE, 32'd0, 32'd1, 8'hFF, 4'd0,  1, 1'b1, ST_OK,       4'd0},
            '{OP_CREATE, 32'd0, 32'd1, 8'h00, 4'd0,  1, 1'b1, ST_OK,       4'd1},
            '{OP_CREATE, 32'd0, 32'd1, 8'hA5, 4'd0,  14, 1'b0, ST_OK,      4'd0},
            '{OP_CREATE, 32'd3, 32'd0, 8'h5A, 4'd0,  1, 1'b1, ST_FULL,     4'd0},
            '{OP_TICK,   32'd0, 32'd0, 8'h00, 4'd0,  3, 1'b0, ST_OK,       4'd0},
            '{OP_DELETE, 32'd0, 32'd0, 8'h00, 4'd1,  1, 1'b1, ST_OK,       4'd1},
            '{OP_DELETE, 32'd0, 32'd0, 8'h00, 4'd1,  1, 1'b1, ST_INACTIVE, 4'd1},
            '{OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h3C, 4'd0, 1, 1'b1, ST_OK, 4'd1},
            '{OP_DELETE, 32'd0, 32'd0, 8'h00, 4'd2,  14, 1'b0, ST_OK,      4'd0},
            '{OP_TICK,   32'd0, 32'd0, 8'h00, 4'd0,  2, 1'b0, ST_OK,       4'd0}
        };

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tbl[k])
            for (int j = 0; j < dir_tbl[k].cnt; j++)
                send_command(dir_tbl[k].op, dir_tbl[k].dly, dir_tbl[k].rpt, dir_tbl[k].q,
                             dir_tbl[k].h + j[3:0], dir_tbl[k].typed, dir_tbl[k].st,
                             dir_tbl[k].ho);

        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(negedge clk);

        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            r = $urandom_range(0, 99);
            op = (r < 45) ? OP_TICK : (r < 80) ? OP_CREATE : (r < 96) ? OP_DELETE : OP_UNUSED;
            dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 8);
            r = $urandom_range(0, 9);
            rpt = (r < 5) ? 32'd0 : (r < 9) ? $urandom_range(1, 6) : $urandom();
            send_command(op, dly, rpt, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                         1'b0, ST_OK, 4'd0);
            if (op != OP_UNUSED)
                sent++;
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        waited = 0;
        while (pending_results.size() > 0 && waited < WATCH_MAX * 4) begin
            @(negedge clk);
            waited++;
        end
        repeat (200) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_in_if.sv
rtl/stq_out_if.sv
rtl/stq_alu.sv
rtl/stq_slot_mem.sv
rtl/sorted_timer_queue.sv
sim/sorted_timer_queue_tb.sv
